### rtl/mdfr_pkg.sv
// mdfr_pkg: shared types and constants for the message deframer
// no dependencies; imported by every deframer module
package mdfr_pkg;

   // framing mode register values
   localparam logic FRAME_NEWLINE = 1'b0;
   localparam logic FRAME_LENGTH  = 1'b1;

   // input word kinds
   localparam logic MODE_DATA    = 1'b0;
   localparam logic MODE_NEWCONN = 1'b1;

   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam int unsigned HEADER_LEN  = 4;
   localparam logic [1:0] HDR_LAST_IDX = 2'(HEADER_LEN - 1);

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       last_of_message;
      logic       empty_message;
   } result_type;

endpackage

### rtl/mdfr_chan_if.sv
// mdfr_req_if / mdfr_rsp_if: valid/ready channels of the deframer
// depends on nothing; used by the deframer top level
interface mdfr_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface mdfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       last_of_message;
   logic       empty_message;

   modport source (output valid, output payload_byte, output last_of_message,
                   output empty_message, input ready);
   modport sink   (input valid, input payload_byte, input last_of_message,
                   input empty_message, output ready);
endinterface

### rtl/mdfr_in_stage.sv
// mdfr_in_stage: input register of the deframer pipeline
// depends on mdfr_pkg
module mdfr_in_stage
   import mdfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  item_type     in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output item_type     out_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   // take a new word when the register is empty or draining
   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      valid_in = take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
      item_in  = take ? in_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### rtl/mdfr_core.sv
// mdfr_core: framing state and per-word decode for both framing modes
// depends on mdfr_pkg
module mdfr_core
   import mdfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       framing_mode,
   input  logic       fire,
   input  item_type   item,
   output logic       res_valid,
   output result_type res
);

   logic        in_payload_ff, in_payload_in;
   logic [1:0]  hdr_seen_ff, hdr_seen_in;
   logic [31:0] remaining_ff, remaining_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;

   logic [31:0] shifted;
   logic [31:0] decremented;

   assign shifted     = {remaining_ff[23:0], item.data_byte};
   assign decremented = remaining_ff - 32'd1;

   // next state and result for one word
   always_comb begin
      in_payload_in = in_payload_ff;
      hdr_seen_in   = hdr_seen_ff;
      remaining_in  = remaining_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      res_valid     = 1'b0;
      res           = '0;

      if (item.mode == MODE_NEWCONN) begin
         in_payload_in = 1'b0;
         hdr_seen_in   = '0;
         remaining_in  = '0;
         held_byte_in  = '0;
         held_valid_in = 1'b0;
      end else if (framing_mode == FRAME_LENGTH) begin
         if (!in_payload_ff) begin
            // gather big-endian length
            remaining_in = shifted;
            if (hdr_seen_ff != HDR_LAST_IDX) begin
               hdr_seen_in = hdr_seen_ff + 2'd1;
            end else begin
               hdr_seen_in = '0;
               if (shifted == '0) begin
                  res_valid           = 1'b1;
                  res.last_of_message = 1'b1;
                  res.empty_message   = 1'b1;
               end else begin
                  in_payload_in = 1'b1;
               end
            end
         end else begin
            // pass payload byte
            remaining_in        = decremented;
            res_valid           = 1'b1;
            res.payload_byte    = item.data_byte;
            res.last_of_message = (decremented == '0);
            if (decremented == '0) begin
               in_payload_in = 1'b0;
            end
         end
      end else begin
         // newline mode with one byte held back
         if (item.data_byte == NEWLINE_CHAR) begin
            if (held_valid_ff) begin
               res_valid           = 1'b1;
               res.payload_byte    = held_byte_ff;
               res.last_of_message = 1'b1;
               held_valid_in       = 1'b0;
               held_byte_in        = '0;
            end
         end else begin
            if (held_valid_ff) begin
               res_valid        = 1'b1;
               res.payload_byte = held_byte_ff;
            end
            held_byte_in  = item.data_byte;
            held_valid_in = 1'b1;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         hdr_seen_ff   <= '0;
         remaining_ff  <= '0;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
      end else if (fire) begin
         in_payload_ff <= in_payload_in;
         hdr_seen_ff   <= hdr_seen_in;
         remaining_ff  <= remaining_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule

### rtl/mdfr_out_stage.sv
// mdfr_out_stage: result register of the deframer pipeline
// depends on mdfr_pkg
module mdfr_out_stage
   import mdfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       res_valid,
   input  result_type res,
   output logic       can_load,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_res
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   // load when empty or when the current word leaves this cycle
   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (can_load) begin
         valid_in = fire && res_valid;
         res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

### rtl/message_deframer_length_or_newline_unit.sv
// message_deframer_length_or_newline_unit: splits a byte stream into messages
// pipeline: an input word passes the input register, then the result register, to become a result word
// throughput: one word per cycle; a stalled result holds the pipe behind it
// reset: synchronous, clears framing state, framing mode (newline) and both stages
// depends on mdfr_pkg, mdfr_chan_if, mdfr_in_stage, mdfr_core, mdfr_out_stage
module message_deframer_length_or_newline_unit
   import mdfr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mdfr_req_if.sink  req_chan,
   mdfr_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   logic         framing_mode_ff, framing_mode_in;
   item_type     req_item, s1_item;
   logic         s1_valid;
   logic         can_load;
   logic         fire;
   logic         res_valid;
   result_type   res, out_res;

   // framing mode register
   assign framing_mode_in = csr_wr_en ? csr_wr_data : framing_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         framing_mode_ff <= FRAME_NEWLINE;
      end else begin
         framing_mode_ff <= framing_mode_in;
      end
   end

   assign req_item.mode      = req_chan.mode;
   assign req_item.data_byte = req_chan.data_byte;

   // input register
   mdfr_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .in_item  (req_item),
      .out_valid(s1_valid),
      .out_ready(can_load),
      .out_item (s1_item)
   );

   // word is processed when it leaves the input register
   assign fire = s1_valid && can_load;

   mdfr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .framing_mode(framing_mode_ff),
      .fire        (fire),
      .item        (s1_item),
      .res_valid   (res_valid),
      .res         (res)
   );

   // result register
   mdfr_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .res_valid(res_valid),
      .res      (res),
      .can_load (can_load),
      .out_valid(rsp_chan.valid),
      .out_ready(rsp_chan.ready),
      .out_res  (out_res)
   );

   assign rsp_chan.payload_byte    = out_res.payload_byte;
   assign rsp_chan.last_of_message = out_res.last_of_message;
   assign rsp_chan.empty_message   = out_res.empty_message;

endmodule
